FILE: rtl/mwg_pkg.sv
// mwg_pkg: shared types and fixed constants of the multi waveform generator
// no dependencies; used by multi_waveform_generator_unit

package mwg_pkg;

    // waveform select codes
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } t_wave;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_COUNT = 3'd3;

    // register widths
    localparam int STEP_W = 32;
    localparam int AMP_W  = 15;
    localparam int RUN_W  = 24;

    // register reset values
    localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;
    localparam logic [RUN_W-1:0] RUN_RESET = 24'd1024;

    // quarter-wave table entries and full-scale level
    localparam int          TBL_W       = 15;
    localparam logic [15:0] SQUARE_PEAK = 16'd32767;

    // pi/2 in q30, seed of the table generation
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

endpackage

FILE: rtl/multi_waveform_generator_unit.sv
// multi_waveform_generator_unit: direct digital synthesis of sine, square,
// triangle and sawtooth samples; depends on mwg_pkg and mwg_ram

// usage
//   configuration: write enable, register index and data; registers are
//   waveform (0), phase_step (1), amplitude (2), sample_count (3); writes to
//   other indexes are dropped; write only while no transfer is in flight
//   input channel: i_valid / o_ready, one transfer asks for one sample;
//   i_restart clears phase and sample index before that sample
//   output channel: o_valid / i_ready carries o_sample_value (signed q1.15)
//   and o_last_sample, high on the final sample of a run, after which the
//   run starts again at phase zero
// timing
//   one sample per clock sustained while i_ready stays high; the input transfer
//   loads the table read and decode register, then the result register loads
//   from it once that register is free
//   when the receiver stalls the result register holds and the stage in
//   front of it still takes one more item, then o_ready drops
// reset
//   synchronous active-low reset loads register defaults, clears phase and
//   index, then the 2^TABLE_ADDR_BITS + 1 quarter-wave table entries (1025
//   by default) are copied into ram with o_ready low;
//   configuration writes are taken during that copy

module multi_waveform_generator_unit #(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS     = 16,
    parameter int COUNT_BITS      = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [mwg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mwg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_restart,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [SAMPLE_BITS-1:0]   o_sample_value,
    output logic                            o_last_sample
);

    // table geometry: entries 0 .. 2^TABLE_ADDR_BITS inclusive
    localparam int TBL_N     = 1 << TABLE_ADDR_BITS;
    localparam int TBL_DEPTH = TBL_N + 1;
    localparam int TBL_AW    = TABLE_ADDR_BITS + 1;

    // amplitude times phase-scaled magnitude
    localparam int PROD_W = PHASE_BITS + mwg_pkg::AMP_W;
    // run length compare width, wide enough for index + 1 and the register
    localparam int CNT_W  = ((COUNT_BITS > mwg_pkg::RUN_W) ? COUNT_BITS : mwg_pkg::RUN_W) + 1;
    // magnitude width ahead of saturation
    localparam int VAL_W  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

    localparam logic [VAL_W-1:0] SAT_LIM = VAL_W'((1 << (SAMPLE_BITS - 1)) - 1);

    localparam logic [PHASE_BITS-1:0] PH_HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PROD_W-1:0]     RND_BIT = PROD_W'(1) << (PHASE_BITS - 2);

    // sin(pi/2 * k / 2^TABLE_ADDR_BITS) * 32767, taylor series in q30
    function automatic logic [mwg_pkg::TBL_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        x    = (64'(k) * mwg_pkg::HALF_PI_Q30) >> TABLE_ADDR_BITS;
        x2   = (x * x) >> 30;
        sum  = signed'(x);
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        if (sum < 0) begin
            sum = 64'sd0;
        end
        r = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[mwg_pkg::TBL_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    mwg_pkg::t_wave              r_waveform;
    logic [mwg_pkg::STEP_W-1:0]  r_phase_step;
    logic [mwg_pkg::AMP_W-1:0]   r_amplitude;
    logic [mwg_pkg::RUN_W-1:0]   r_sample_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform     <= mwg_pkg::WAVE_SINE;
            r_phase_step   <= '0;
            r_amplitude    <= mwg_pkg::AMP_RESET;
            r_sample_count <= mwg_pkg::RUN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mwg_pkg::CFG_WAVEFORM: begin
                    r_waveform <= mwg_pkg::t_wave'(i_cfg_data[1:0]);
                end
                mwg_pkg::CFG_PHASE_STEP: begin
                    r_phase_step <= i_cfg_data[mwg_pkg::STEP_W-1:0];
                end
                mwg_pkg::CFG_AMPLITUDE: begin
                    r_amplitude <= i_cfg_data[mwg_pkg::AMP_W-1:0];
                end
                mwg_pkg::CFG_SAMPLE_COUNT: begin
                    r_sample_count <= i_cfg_data[mwg_pkg::RUN_W-1:0];
                end
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // table copy after reset
    // ------------------------------------------------------------------
    logic [mwg_pkg::TBL_W-1:0] sine_tbl [TBL_DEPTH];

    for (genvar gk = 0; gk < TBL_DEPTH; gk++) begin : g_tbl
        localparam logic [mwg_pkg::TBL_W-1:0] ENTRY = sine_entry(gk);
        assign sine_tbl[gk] = ENTRY;
    end

    logic              r_filling;
    logic [TBL_AW-1:0] r_fill_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filling   <= 1'b1;
            r_fill_addr <= '0;
        end else if (r_filling) begin
            if (r_fill_addr == TBL_AW'(TBL_N)) begin
                r_filling <= 1'b0;
            end else begin
                r_fill_addr <= r_fill_addr + TBL_AW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // handshake and pipeline control
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_free;
    logic in_xfer;
    logic s1_xfer;

    // result register empties or is being taken this cycle
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_filling && (!r_s1_valid || out_free);
    assign in_xfer  = i_valid && o_ready;
    assign s1_xfer  = r_s1_valid && out_free;

    // ------------------------------------------------------------------
    // accept stage: phase accumulator, run counter, shape decode
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [COUNT_BITS-1:0] r_sample_index;
    logic [PHASE_BITS-1:0] n_phase_acc;
    logic [COUNT_BITS-1:0] n_sample_index;

    logic [PHASE_BITS-1:0]      cur_phase;
    logic [COUNT_BITS-1:0]      cur_index;
    logic [CNT_W-1:0]           index_plus;
    logic [CNT_W-1:0]           run_len;
    logic [1:0]                 quad;
    logic [TABLE_ADDR_BITS-1:0] tbl_off;
    logic [TBL_AW-1:0]          rd_addr;

    logic                  n_s1_last;
    logic                  n_s1_neg;
    logic                  n_s1_zero;
    logic [PHASE_BITS-1:0] n_s1_mag;

    // restart clears phase and index ahead of this sample
    assign cur_phase = i_restart ? '0 : r_phase_acc;
    assign cur_index = i_restart ? '0 : r_sample_index;

    // a zero run length acts as one; index at or past the end marks last
    assign index_plus = CNT_W'(cur_index) + CNT_W'(1);
    assign run_len    = (r_sample_count == '0) ? CNT_W'(1) : CNT_W'(r_sample_count);
    assign n_s1_last  = index_plus >= run_len;

    // last sample rewinds the run, otherwise step on
    assign n_phase_acc    = n_s1_last ? '0 : cur_phase + PHASE_BITS'(r_phase_step);
    assign n_sample_index = n_s1_last ? '0 : cur_index + COUNT_BITS'(1);

    // sine address: mirrored in odd quadrants, entry 2^N sits at quarter phase
    assign quad    = cur_phase[PHASE_BITS-1 -: 2];
    assign tbl_off = cur_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign rd_addr = quad[0] ? (TBL_AW'(TBL_N) - {1'b0, tbl_off}) : {1'b0, tbl_off};

    // magnitude and sign per waveform; every magnitude is scaled so that a value
    // of PH_HALF maps to full amplitude and one rounding shift serves all but square
    always_comb begin
        n_s1_neg  = 1'b0;
        n_s1_zero = 1'b0;
        n_s1_mag  = '0;
        case (r_waveform)
            mwg_pkg::WAVE_SINE: begin
                // magnitude comes from the table read
                n_s1_neg = quad[1];
            end
            mwg_pkg::WAVE_SQUARE: begin
                // zero at phase zero and at half period
                n_s1_neg  = cur_phase[PHASE_BITS-1];
                n_s1_zero = (cur_phase[PHASE_BITS-2:0] == '0);
            end
            mwg_pkg::WAVE_TRIANGLE: begin
                // distance from the nearest zero crossing, doubled
                case (quad)
                    2'b00: begin
                        n_s1_mag = cur_phase << 1;
                    end
                    2'b01, 2'b10: begin
                        if (cur_phase <= PH_HALF) begin
                            n_s1_mag = (PH_HALF - cur_phase) << 1;
                        end else begin
                            n_s1_neg = 1'b1;
                            n_s1_mag = (cur_phase - PH_HALF) << 1;
                        end
                    end
                    default: begin
                        n_s1_neg = 1'b1;
                        n_s1_mag = (PHASE_BITS'(0) - cur_phase) << 1;
                    end
                endcase
            end
            default: begin
                // sawtooth, -amplitude at phase zero
                if (cur_phase[PHASE_BITS-1]) begin
                    n_s1_mag = cur_phase - PH_HALF;
                end else begin
                    n_s1_neg = 1'b1;
                    n_s1_mag = PH_HALF - cur_phase;
                end
            end
        endcase
    end

    mwg_pkg::t_wave        r_s1_wave;
    logic                  r_s1_last;
    logic                  r_s1_neg;
    logic                  r_s1_zero;
    logic [PHASE_BITS-1:0] r_s1_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc    <= '0;
            r_sample_index <= '0;
            r_s1_valid     <= 1'b0;
        end else if (in_xfer) begin
            r_phase_acc    <= n_phase_acc;
            r_sample_index <= n_sample_index;
            r_s1_valid     <= 1'b1;
        end else if (s1_xfer) begin
            r_s1_valid     <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_wave <= r_waveform;
            r_s1_last <= n_s1_last;
            r_s1_neg  <= n_s1_neg;
            r_s1_zero <= n_s1_zero;
            r_s1_mag  <= n_s1_mag;
        end
    end

    // quarter-wave table, read on the input transfer
    logic [mwg_pkg::TBL_W-1:0] tbl_rdata;

    mwg_ram #(
        .WIDTH (mwg_pkg::TBL_W),
        .DEPTH (TBL_DEPTH)
    ) u_sine_ram (
        .i_clk   (i_clk),
        .i_we    (r_filling),
        .i_waddr (r_fill_addr),
        .i_wdata (sine_tbl[r_fill_addr]),
        .i_re    (in_xfer),
        .i_raddr (rd_addr),
        .o_rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------
    // scale stage: shared multiplier, rounding, sign, saturation
    // ------------------------------------------------------------------
    logic [PHASE_BITS-1:0]  mult_mag;
    logic [PROD_W-1:0]      product;
    logic [PROD_W-1:0]      product_rnd;
    logic [15:0]            level;
    logic [VAL_W-1:0]       level_wide;
    logic [VAL_W-1:0]       level_sat;
    logic [SAMPLE_BITS-1:0] n_out_sample;

    // table entry aligned so the shared shift gives (t * amp + 2^14) >> 15
    assign mult_mag = (r_s1_wave == mwg_pkg::WAVE_SINE)
                    ? (PHASE_BITS'(tbl_rdata) << (PHASE_BITS - 16))
                    : r_s1_mag;

    assign product     = PROD_W'(r_amplitude) * PROD_W'(mult_mag);
    assign product_rnd = product + RND_BIT;

    // square ignores amplitude
    always_comb begin
        if (r_s1_wave == mwg_pkg::WAVE_SQUARE) begin
            level = r_s1_zero ? 16'd0 : mwg_pkg::SQUARE_PEAK;
        end else begin
            level = product_rnd[PROD_W-1 -: 16];
        end
    end

    assign level_wide   = VAL_W'(level);
    assign level_sat    = (level_wide > SAT_LIM) ? SAT_LIM : level_wide;
    assign n_out_sample = r_s1_neg ? (SAMPLE_BITS'(0) - level_sat[SAMPLE_BITS-1:0])
                                   : level_sat[SAMPLE_BITS-1:0];

    logic [SAMPLE_BITS-1:0] r_out_sample;
    logic                   r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_xfer) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_xfer) begin
            r_out_sample <= n_out_sample;
            r_out_last   <= r_s1_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_value = signed'(r_out_sample);
    assign o_last_sample  = r_out_last;

`ifndef SYNTHESIS
    // reset starts the table copy with both stages empty
    a_reset_fill: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_filling && !r_s1_valid && !r_out_valid))
        else $error("table copy not started or pipeline not empty after reset");

    // no sample is taken while the table is being copied
    a_no_xfer_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filling |-> !in_xfer)
        else $error("input transfer during table copy");

    // the scale stage never holds an item read from an unfilled table
    a_s1_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !r_filling)
        else $error("scale stage valid during table copy");

    // a last sample rewinds phase and index
    a_last_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && n_s1_last) |=> (r_phase_acc == '0 && r_sample_index == '0))
        else $error("run did not restart after last sample");

    // a stalled result is not overwritten by the stage behind it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !s1_xfer)
        else $error("result register overwritten while stalled");
`endif

endmodule

FILE: rtl/mwg_ram.sv
// mwg_ram: generic single write port, single read port ram with registered read
// no dependencies; holds the quarter-wave sine table

module mwg_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
